// ----- src/isc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types and constants of the interval scheduling counter.
// ----------------------------------------------------------------------------
`default_nettype none

package isc_pkg;

  localparam int TimeW   = 16;
  localparam int CountW  = 8;
  localparam int QDepth  = 2;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);

  typedef struct packed {
    logic [TimeW-1:0] start_time;
    logic [TimeW-1:0] end_time;
    logic             last_item;
  } isc_item_t;

  typedef struct packed {
    logic [CountW-1:0] selected_count;
    logic              overflow;
  } isc_res_t;

  typedef enum logic {
    StFill,
    StScan
  } isc_state_e;

endpackage

`default_nettype wire

// ----- src/isc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_in_if / isc_out_if
// Valid/ready channels for interval beats and count results.
// ----------------------------------------------------------------------------
`default_nettype none

interface isc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] start_time;
  logic [15:0] end_time;
  logic        last_item;

  modport source (output valid, output start_time, output end_time, output last_item,
                  input ready);
  modport sink   (input valid, input start_time, input end_time, input last_item,
                  output ready);
endinterface

interface isc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] selected_count;
  logic       overflow;

  modport source (output valid, output selected_count, output overflow, input ready);
  modport sink   (input valid, input selected_count, input overflow, output ready);
endinterface

`default_nettype wire

// ----- src/isc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_front
// Input stage: takes interval beats, masks times to the active width.
// ----------------------------------------------------------------------------
`default_nettype none

module isc_front #(
  parameter int TIME_BITS = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  isc_pkg::isc_item_t in_item_i,
  output logic               q_valid_o,
  input  wire                q_ready_i,
  output isc_pkg::isc_item_t q_item_o
);
  import isc_pkg::*;

  localparam int TW = (TIME_BITS < TimeW) ? TIME_BITS : TimeW;
  localparam logic [TimeW-1:0] TimeMask = {TimeW{1'b1}} >> (TimeW - TW);

  logic      vld_q, vld_d;
  isc_item_t item_q;
  logic      take;

  assign in_ready_o = !vld_q || q_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (q_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.start_time <= in_item_i.start_time & TimeMask;
      item_q.end_time   <= in_item_i.end_time & TimeMask;
      item_q.last_item  <= in_item_i.last_item;
    end
  end

  assign q_valid_o = vld_q;
  assign q_item_o  = item_q;

endmodule

`default_nettype wire

// ----- src/isc_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_fifo
// Short queue between the input stage and the sort/scan engine.
// ----------------------------------------------------------------------------
`default_nettype none

module isc_fifo (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_valid_i,
  output logic               push_ready_o,
  input  isc_pkg::isc_item_t push_item_i,
  output logic               pop_valid_o,
  input  wire                pop_ready_i,
  output isc_pkg::isc_item_t pop_item_o
);
  import isc_pkg::*;

  isc_item_t        mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/isc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_back
// Insertion-sort cell chain ordered by end time, greedy scan, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module isc_back #(
  parameter int MAX_INTERVALS = 128,
  parameter int TIME_BITS     = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                pop_valid_i,
  output logic               pop_ready_o,
  input  isc_pkg::isc_item_t pop_item_i,
  output logic               res_valid_o,
  input  wire                res_ready_i,
  output isc_pkg::isc_res_t  res_o
);
  import isc_pkg::*;

  localparam int N  = MAX_INTERVALS;
  localparam int TW = (TIME_BITS < TimeW) ? TIME_BITS : TimeW;
  localparam int CW = $clog2(N + 1);

  isc_state_e    state_q, state_d;
  logic [TW-1:0] cs_q [N];
  logic [TW-1:0] ce_q [N];
  logic [N-1:0]  cv_q;
  logic [N-1:0]  ins;
  logic [CW-1:0] cnt_q, taken_q;
  logic          ovf_q;
  logic [TW-1:0] last_end_q;
  logic          last_vld_q;
  logic          res_vld_q;
  isc_res_t      res_q;

  logic          pop, do_ins, do_shift, take_head, emit;
  logic [TW-1:0] new_s, new_e;
  logic [CW+7:0] taken_ext;

  assign new_s = pop_item_i.start_time[TW-1:0];
  assign new_e = pop_item_i.end_time[TW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StFill: if (pop && pop_item_i.last_item) state_d = StScan;
      StScan: if (emit) state_d = StFill;
      default: state_d = StFill;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop_ready_o = 1'b0;
    do_shift    = 1'b0;
    emit        = 1'b0;
    unique case (state_q)
      StFill: pop_ready_o = 1'b1;
      StScan: begin
        do_shift = cv_q[0];
        emit     = !cv_q[0] && (!res_vld_q || res_ready_i);
      end
      default: ;
    endcase
  end

  assign pop       = pop_valid_i && pop_ready_o;
  assign do_ins    = pop && (cnt_q != CW'(N));
  assign take_head = do_shift && (!last_vld_q || cs_q[0] >= last_end_q);
  assign taken_ext = (CW + 8)'(taken_q);

  // a cell opens for the new beat when empty or when its end is later (stable)
  always_comb begin
    for (int i = 0; i < N; i++) begin
      ins[i] = !cv_q[i] || (ce_q[i] > new_e);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StFill;
      cv_q       <= '0;
      cnt_q      <= '0;
      taken_q    <= '0;
      ovf_q      <= 1'b0;
      last_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_ins) begin
        for (int i = 0; i < N; i++) begin
          if (ins[i]) begin
            cv_q[i] <= (i > 0 && ins[(i > 0) ? i - 1 : 0]) ? cv_q[(i > 0) ? i - 1 : 0] : 1'b1;
          end
        end
        cnt_q <= cnt_q + 1'b1;
      end else if (pop) begin
        ovf_q <= 1'b1;
      end
      if (do_shift) begin
        cv_q <= {1'b0, cv_q[N-1:1]};
      end
      if (take_head) begin
        last_vld_q <= 1'b1;
        taken_q    <= taken_q + 1'b1;
      end
      if (emit) begin
        res_vld_q  <= 1'b1;
        cnt_q      <= '0;
        taken_q    <= '0;
        ovf_q      <= 1'b0;
        last_vld_q <= 1'b0;
      end else if (res_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_ins) begin
      for (int i = 0; i < N; i++) begin
        if (ins[i]) begin
          if (i > 0 && ins[(i > 0) ? i - 1 : 0]) begin
            cs_q[i] <= cs_q[(i > 0) ? i - 1 : 0];
            ce_q[i] <= ce_q[(i > 0) ? i - 1 : 0];
          end else begin
            cs_q[i] <= new_s;
            ce_q[i] <= new_e;
          end
        end
      end
    end else if (do_shift) begin
      for (int i = 0; i < N - 1; i++) begin
        cs_q[i] <= cs_q[i+1];
        ce_q[i] <= ce_q[i+1];
      end
    end
    if (take_head) begin
      last_end_q <= ce_q[0];
    end
    if (emit) begin
      res_q.selected_count <= (taken_ext > (CW + 8)'(255)) ? 8'hFF : taken_ext[7:0];
      res_q.overflow       <= ovf_q;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFill) |-> ($countones(cv_q) == int'(cnt_q)))
    else $error("cell occupancy does not match stored count");

  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cv_q & (cv_q + 1'b1)) == '0))
    else $error("occupied cells are not a prefix of the chain");

  a_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(emit) |-> (cv_q == '0 && cnt_q == '0 && taken_q == '0 && !ovf_q))
    else $error("batch state not cleared after result");

  a_scan_idle_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> !pop)
    else $error("beat taken during scan");

endmodule

`default_nettype wire

// ----- src/interval_schedule_max_count.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_schedule_max_count
// Maximum count of non-overlapping intervals in a batch (earliest finish).
// ----------------------------------------------------------------------------
// Input channel in_i carries one interval per beat (start_time, end_time,
// last_item). Times are masked to TIME_BITS. Beats go through a registered
// input stage and a two-entry queue into a chain of MAX_INTERVALS cells that
// keeps them ordered by end time; the chain takes one beat per cycle while
// filling. A beat with last_item set starts the scan: the chain shifts out
// one cell per cycle through a single compare and, once empty, posts the
// result when the output register is free; until then no new beat enters
// the chain (the queue and input stage still fill). The result beat on out_o
// carries selected_count (saturating at 255) and overflow, set when beats
// beyond MAX_INTERVALS were dropped. The result sits in an output register;
// a stalled receiver holds it and the next batch fills and scans the chain
// meanwhile, but its result waits for the register to drain. Reset empties
// queue, chain and result.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_schedule_max_count #(
  parameter int MAX_INTERVALS = 128,
  parameter int TIME_BITS     = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  isc_in_if.sink     in_i,
  isc_out_if.source  out_o
);
  import isc_pkg::*;

  isc_item_t in_item, fq_item, bq_item;
  logic      fq_valid, fq_ready, bq_valid, bq_ready;
  logic      res_valid;
  isc_res_t  res;
  logic      in_ready;

  assign in_item.start_time = in_i.start_time;
  assign in_item.end_time   = in_i.end_time;
  assign in_item.last_item  = in_i.last_item;
  assign in_i.ready         = in_ready;

  isc_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_item_o   (fq_item)
  );

  isc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_item_i  (fq_item),
    .pop_valid_o  (bq_valid),
    .pop_ready_i  (bq_ready),
    .pop_item_o   (bq_item)
  );

  isc_back #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .TIME_BITS     (TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (bq_valid),
    .pop_ready_o (bq_ready),
    .pop_item_i  (bq_item),
    .res_valid_o (res_valid),
    .res_ready_i (out_o.ready),
    .res_o       (res)
  );

  assign out_o.valid          = res_valid;
  assign out_o.selected_count = res.selected_count;
  assign out_o.overflow       = res.overflow;

endmodule

`default_nettype wire

// ----- tb/interval_schedule_max_count_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_schedule_max_count_checker
// Watches the interval and count channels and scores every result beat.
// ----------------------------------------------------------------------------
// Each accepted interval beat, up to MAX_INTERVALS, is filed into a local
// copy of the batch, kept ordered by end time; equal ends keep arrival order.
// A beat with last_item set closes the batch. The copy is then walked
// greedily, earliest finish first, and the expected count and overflow are
// queued. Each result beat is compared field by field with the oldest entry
// in that queue. The failure count and the number of results still owed go
// to the testbench top.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_schedule_max_count_checker #(
  parameter int MAX_INTERVALS = 128,
  parameter int TIME_BITS     = 16
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  isc_in_if    in_mon,
  isc_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o
);
  import isc_pkg::*;

  typedef struct packed {
    logic [TimeW-1:0] start_time;
    logic [TimeW-1:0] end_time;
  } span_t;

  span_t       batch_spans[MAX_INTERVALS];
  int unsigned batch_len;
  logic        batch_spilled;
  isc_res_t    count_q[$];

  function automatic logic [TimeW-1:0] clip_time(input logic [TimeW-1:0] t);
    logic [31:0] mask;
    mask = (TIME_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << TIME_BITS) - 32'd1);
    return t & mask[TimeW-1:0];
  endfunction

  // stable insert: goes after every held span with an equal end
  function automatic void file_span(input span_t sp);
    int unsigned pos;
    pos = batch_len;
    while (pos > 0 && batch_spans[pos-1].end_time > sp.end_time) begin
      batch_spans[pos] = batch_spans[pos-1];
      pos--;
    end
    batch_spans[pos] = sp;
    batch_len++;
  endfunction

  function automatic isc_res_t best_schedule();
    isc_res_t         res;
    int unsigned      taken;
    logic             have_end;
    logic [TimeW-1:0] end_mark;
    taken    = 0;
    have_end = 1'b0;
    end_mark = '0;
    for (int unsigned i = 0; i < batch_len; i++) begin
      if (!have_end || batch_spans[i].start_time >= end_mark) begin
        end_mark = batch_spans[i].end_time;
        have_end = 1'b1;
        taken++;
      end
    end
    res.selected_count = (taken > 255) ? 8'd255 : taken[CountW-1:0];
    res.overflow       = batch_spilled;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    isc_res_t seen;
    isc_res_t want;
    span_t    sp;
    if (!rst_ni) begin
      batch_len     = 0;
      batch_spilled = 1'b0;
      count_q.delete();
      fail_count_o  = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        seen.selected_count = out_mon.selected_count;
        seen.overflow       = out_mon.overflow;
        if (count_q.size() == 0) begin
          $display("%0t: unexpected count beat, got selected_count %0d overflow %0b",
                   $time, seen.selected_count, seen.overflow);
          fail_count_o++;
        end else begin
          want = count_q.pop_front();
          if (seen.selected_count !== want.selected_count) begin
            $display("%0t: selected_count mismatch, expected %0d got %0d",
                     $time, want.selected_count, seen.selected_count);
            fail_count_o++;
          end
          if (seen.overflow !== want.overflow) begin
            $display("%0t: overflow mismatch, expected %0b got %0b",
                     $time, want.overflow, seen.overflow);
            fail_count_o++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        sp.start_time = clip_time(in_mon.start_time);
        sp.end_time   = clip_time(in_mon.end_time);
        if (batch_len < MAX_INTERVALS) begin
          file_span(sp);
        end else begin
          batch_spilled = 1'b1;
        end
        if (in_mon.last_item) begin
          count_q.push_back(best_schedule());
          batch_len     = 0;
          batch_spilled = 1'b0;
        end
      end
    end
    pending_o = count_q.size();
  end

endmodule

`default_nettype wire

// ----- tb/interval_schedule_max_count_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_schedule_max_count_tb
// Stimulus and verdict for the interval scheduling counter.
// ----------------------------------------------------------------------------
// A short directed set comes first: single and extreme intervals, reversed
// spans, tied ends, touching and nested spans. Random batches follow. Most
// are small and use wide, tight, chained or edge spans. A few are near the
// store size, fill it exactly or run past it, and the beat that closes some
// of those is dropped. Both sides idle at random, with bursts of back-to-back
// beats. Now and then the sender holds off until every count has come back.
// The checker scores the results; a watchdog ends a stalled run.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_schedule_max_count_tb;
  import isc_pkg::*;

  localparam int MaxIntervals = 128;
  localparam int TimeBits     = 16;
  localparam int RandItems    = 1530;
  localparam int StallLimit   = 4000;

  typedef enum int {
    SpanWide,
    SpanTight,
    SpanChain,
    SpanEdge
  } span_style_e;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending_counts;
  int   idle_cycles;
  int   send_burst;
  int   take_burst;

  isc_in_if  interval_ch ();
  isc_out_if count_ch ();

  interval_schedule_max_count #(
    .MAX_INTERVALS(MaxIntervals),
    .TIME_BITS    (TimeBits)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (interval_ch),
    .out_o (count_ch)
  );

  interval_schedule_max_count_checker #(
    .MAX_INTERVALS(MaxIntervals),
    .TIME_BITS    (TimeBits)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (interval_ch),
    .out_mon     (count_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending_counts)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  function automatic logic [15:0] edge_time();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send_interval(input logic [15:0] s, input logic [15:0] e,
                               input logic last);
    int gap;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      interval_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    interval_ch.valid      <= 1'b1;
    interval_ch.start_time <= s;
    interval_ch.end_time   <= e;
    interval_ch.last_item  <= last;
    @(posedge clk_i);
    while (!interval_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_counts();
    interval_ch.valid <= 1'b0;
    while (pending_counts != 0) @(negedge clk_i);
  endtask

  task automatic send_batch(input int size, input span_style_e style);
    logic [15:0] ss[$];
    logic [15:0] es[$];
    logic [15:0] s;
    logic [15:0] e;
    logic [15:0] tmp;
    int          cursor;
    int          j;
    cursor = $urandom_range(0, 60000);
    for (int i = 0; i < size; i++) begin
      case (style)
        SpanWide: begin
          s = 16'($urandom);
          e = 16'($urandom);
        end
        SpanTight: begin
          s = 16'($urandom_range(0, 40));
          e = s + 16'($urandom_range(0, 8));
        end
        SpanChain: begin
          s      = 16'(cursor + $urandom_range(0, 2));
          e      = s + 16'($urandom_range(0, 3));
          cursor = int'(e);
        end
        default: begin
          s = edge_time();
          e = edge_time();
        end
      endcase
      ss.push_back(s);
      es.push_back(e);
    end
    for (int i = size - 1; i > 0; i--) begin
      j     = $urandom_range(0, i);
      tmp   = ss[i];
      ss[i] = ss[j];
      ss[j] = tmp;
      tmp   = es[i];
      es[i] = es[j];
      es[j] = tmp;
    end
    for (int i = 0; i < size; i++) begin
      send_interval(ss[i], es[i], i == size - 1);
    end
  endtask

  // receiver: random stall before each count beat
  initial begin
    int take_wait;
    count_ch.ready = 1'b0;
    take_burst     = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      take_wait = draw_wait(take_burst);
      if (take_wait > 0) begin
        count_ch.ready <= 1'b0;
        repeat (take_wait) @(negedge clk_i);
      end
      count_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!count_ch.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((interval_ch.valid && interval_ch.ready) ||
                 (count_ch.valid && count_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          sent;
    int          batch_no;
    int          size;
    span_style_e style;
    rst_ni                 = 1'b0;
    interval_ch.valid      = 1'b0;
    interval_ch.start_time = '0;
    interval_ch.end_time   = '0;
    interval_ch.last_item  = 1'b0;
    send_burst             = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single zero-length interval
    send_interval(16'h0000, 16'h0000, 1'b1);
    // time extremes
    send_interval(16'hFFFF, 16'hFFFF, 1'b0);
    send_interval(16'h0000, 16'hFFFF, 1'b0);
    send_interval(16'h0000, 16'h0000, 1'b1);
    // reversed span
    send_interval(16'd100, 16'd50, 1'b0);
    send_interval(16'd60, 16'd70, 1'b0);
    send_interval(16'd40, 16'd45, 1'b1);
    // tied ends
    send_interval(16'd0, 16'd10, 1'b0);
    send_interval(16'd5, 16'd10, 1'b0);
    send_interval(16'd10, 16'd10, 1'b0);
    send_interval(16'd10, 16'd20, 1'b1);
    // touching spans, out of order
    send_interval(16'd0, 16'd5, 1'b0);
    send_interval(16'd10, 16'd15, 1'b0);
    send_interval(16'd5, 16'd10, 1'b1);
    // alternating bit patterns
    send_interval(16'hAAAA, 16'h5555, 1'b0);
    send_interval(16'h5555, 16'hAAAA, 1'b0);
    send_interval(16'h5555, 16'h5555, 1'b1);
    // nested spans
    send_interval(16'd0, 16'd100, 1'b0);
    send_interval(16'd10, 16'd20, 1'b0);
    send_interval(16'd30, 16'd40, 1'b0);
    send_interval(16'd20, 16'd30, 1'b1);
    drain_counts();

    sent     = 0;
    batch_no = 0;
    while (sent < RandItems) begin
      style = span_style_e'($urandom_range(0, 3));
      if (batch_no == 0) begin
        size  = MaxIntervals;
        style = SpanChain;
      end else if (batch_no == 1) begin
        size  = MaxIntervals + 3;
        style = SpanChain;
      end else if ($urandom_range(0, 29) == 0) begin
        size = $urandom_range(MaxIntervals - 2, MaxIntervals + 3);
      end else begin
        size = $urandom_range(1, 12);
      end
      send_batch(size, style);
      sent += size;
      batch_no++;
      if ($urandom_range(0, 39) == 0) begin
        drain_counts();
      end
    end
    drain_counts();
    repeat (MaxIntervals + 20) @(negedge clk_i);

    if (fail_count == 0 && pending_counts == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
